### design/kstcd_pkg.sv
`default_nettype none

package kstcd_pkg;

    // Table geometry.
    localparam int NUM_SLOTS    = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int KEY_W        = 32;
    localparam int IDX_W        = $clog2(NUM_SLOTS);
    localparam int FILL_W       = $clog2(NUM_SLOTS + 1);

    // Capacity register after reset.
    localparam logic [FILL_W-1:0] CAP_RESET = FILL_W'(NUM_SLOTS);

    // Operation codes.
    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_DELETE  = 2'd1;
    localparam logic [1:0] MODE_FIND    = 2'd2;
    localparam logic [1:0] MODE_COMPACT = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_DUPLICATE = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    // One stored record; the live flag is kept apart in flip-flops.
    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic [KEY_W-1:0]        parent;
        logic [KEY_W-1:0]        key;
    } slot_rec_t;

endpackage

`default_nettype wire

### design/keyed_slot_table_cascade_delete_unit.sv
// A finished result waits in ST_FINISH while an earlier result is still stalled on m_axis_tready.
// Throughput: one transaction at a time; each pass streams one slot per cycle through the
// single read port of the record memory, so an item costs one or two passes over the fill mark.
// Reset (aresetn low, synchronous) clears all live flags, the fill mark and the result
// valid, and sets the capacity to 64; the record memory itself is not cleared.
`default_nettype none

module keyed_slot_table_cascade_delete_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Capacity register write.
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata,
    // Request stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // key[31:0], parent_key[63:32], payload[95:64]
    input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata   // status[1:0], slot_index[7:2],
                                            // payload_out[39:8], fill_count[46:40], zero[47]
);

    localparam int IDX_W  = kstcd_pkg::IDX_W;
    localparam int FILL_W = kstcd_pkg::FILL_W;
    localparam int NSLOT  = kstcd_pkg::NUM_SLOTS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DELETE,
        ST_COMPACT,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // Control state.
    state_t              state_reg, state_next;
    logic [NSLOT-1:0]    live_reg, live_next;
    logic [FILL_W-1:0]   used_reg, used_next;
    logic [FILL_W-1:0]   cap_reg, cap_next;
    logic [FILL_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [FILL_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic                m_valid_reg, m_valid_next;

    // Datapath registers.
    logic [1:0]                       op_mode_reg, op_mode_next;
    kstcd_pkg::slot_rec_t             op_rec_reg, op_rec_next;
    logic [IDX_W-1:0]                 cmp_idx_reg, cmp_idx_next;
    logic [1:0]                       res_status_reg, res_status_next;
    logic [IDX_W-1:0]                 res_slot_reg, res_slot_next;
    logic [kstcd_pkg::PAYLOAD_BITS-1:0] res_pay_reg, res_pay_next;
    logic [1:0]                       out_status_reg, out_status_next;
    logic [IDX_W-1:0]                 out_slot_reg, out_slot_next;
    logic [kstcd_pkg::PAYLOAD_BITS-1:0] out_pay_reg, out_pay_next;
    logic [FILL_W-1:0]                out_fill_reg, out_fill_next;

    // Record memory with one write and one registered read port.
    kstcd_pkg::slot_rec_t mem [NSLOT];
    kstcd_pkg::slot_rec_t rd_data_reg;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    kstcd_pkg::slot_rec_t mem_wdata;

    // Helpers.
    logic              in_accept;
    logic [FILL_W-1:0] cap_lim;
    logic              scanning;
    logic              scan_issue;
    logic              scan_done;
    logic              cmp_live;
    logic              key_match;
    logic              parent_match;
    logic              out_free;

    assign in_accept    = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cap_lim      = (cap_reg > FILL_W'(NSLOT)) ? FILL_W'(NSLOT) : cap_reg;
    assign scanning     = (state_reg == ST_LOOKUP) || (state_reg == ST_DELETE) ||
                          (state_reg == ST_COMPACT);
    assign scan_issue   = scanning && (rd_idx_reg < used_reg);
    assign scan_done    = !cmp_vld_reg && (rd_idx_reg >= used_reg);
    assign cmp_live     = live_reg[cmp_idx_reg];
    assign key_match    = cmp_vld_reg && cmp_live && (rd_data_reg.key == op_rec_reg.key);
    assign parent_match = cmp_vld_reg && cmp_live &&
                          (rd_data_reg.parent == op_rec_reg.key);
    assign out_free     = !m_valid_reg || m_axis_tready;
    assign rd_en        = scan_issue;
    assign rd_addr      = rd_idx_reg[IDX_W-1:0];

    // Sequencer: lookup, cascade delete and compaction passes stream one slot per cycle.
    always_comb begin
        state_next      = state_reg;
        live_next       = live_reg;
        used_next       = used_reg;
        cap_next        = cfg_we ? cfg_wdata : cap_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        wr_ptr_next     = wr_ptr_reg;
        m_valid_next    = m_axis_tready ? 1'b0 : m_valid_reg;
        op_mode_next    = op_mode_reg;
        op_rec_next     = op_rec_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_pay_next    = res_pay_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_pay_next    = out_pay_reg;
        out_fill_next   = out_fill_reg;
        mem_we          = 1'b0;
        mem_waddr       = used_reg[IDX_W-1:0];
        mem_wdata       = op_rec_reg;

        // Read issue stage shared by all passes.
        if (scan_issue) begin
            rd_idx_next  = rd_idx_reg + FILL_W'(1);
            cmp_vld_next = 1'b1;
            cmp_idx_next = rd_idx_reg[IDX_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    op_mode_next        = s_axis_tuser;
                    op_rec_next.key     = s_axis_tdata[31:0];
                    op_rec_next.parent  = s_axis_tdata[63:32];
                    op_rec_next.payload = s_axis_tdata[95:64];
                    res_status_next     = kstcd_pkg::STAT_OK;
                    res_slot_next       = '0;
                    res_pay_next        = '0;
                    rd_idx_next         = '0;
                    wr_ptr_next         = '0;
                    state_next = (s_axis_tuser == kstcd_pkg::MODE_COMPACT) ?
                                 ST_COMPACT : ST_LOOKUP;
                end
            end

            ST_LOOKUP: begin
                if (key_match) begin
                    rd_idx_next   = '0;
                    cmp_vld_next  = 1'b0;
                    res_slot_next = cmp_idx_reg;
                    unique case (op_mode_reg)
                        kstcd_pkg::MODE_INSERT: begin
                            res_status_next = kstcd_pkg::STAT_DUPLICATE;
                            res_slot_next   = '0;
                            state_next      = ST_FINISH;
                        end
                        kstcd_pkg::MODE_DELETE: begin
                            live_next[cmp_idx_reg] = 1'b0;
                            state_next             = ST_DELETE;
                        end
                        kstcd_pkg::MODE_FIND: begin
                            res_pay_next = rd_data_reg.payload;
                            state_next   = ST_FINISH;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end else if (scan_done) begin
                    rd_idx_next = '0;
                    if (op_mode_reg == kstcd_pkg::MODE_INSERT) begin
                        state_next = (used_reg >= cap_lim) ? ST_COMPACT : ST_WRITE;
                    end else begin
                        res_status_next = kstcd_pkg::STAT_NOT_FOUND;
                        state_next      = ST_FINISH;
                    end
                end
            end

            // Clear every live direct child of the deleted key.
            ST_DELETE: begin
                if (parent_match) begin
                    live_next[cmp_idx_reg] = 1'b0;
                end
                if (scan_done) begin
                    state_next = ST_FINISH;
                end
            end

            // Move live records down to the write pointer in order.
            ST_COMPACT: begin
                if (cmp_vld_reg && cmp_live) begin
                    if (cmp_idx_reg != wr_ptr_reg[IDX_W-1:0]) begin
                        mem_we                             = 1'b1;
                        mem_waddr                          = wr_ptr_reg[IDX_W-1:0];
                        mem_wdata                          = rd_data_reg;
                        live_next[wr_ptr_reg[IDX_W-1:0]]   = 1'b1;
                        live_next[cmp_idx_reg]             = 1'b0;
                    end
                    wr_ptr_next = wr_ptr_reg + FILL_W'(1);
                end
                if (scan_done) begin
                    used_next = wr_ptr_reg;
                    if (op_mode_reg == kstcd_pkg::MODE_INSERT) begin
                        if (wr_ptr_reg >= cap_lim) begin
                            res_status_next = kstcd_pkg::STAT_FULL;
                            state_next      = ST_FINISH;
                        end else begin
                            state_next = ST_WRITE;
                        end
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end

            // Append the new record at the fill mark.
            ST_WRITE: begin
                mem_we                         = 1'b1;
                live_next[used_reg[IDX_W-1:0]] = 1'b1;
                used_next                      = used_reg + FILL_W'(1);
                res_slot_next                  = used_reg[IDX_W-1:0];
                state_next                     = ST_FINISH;
            end

            // Hand the result to the output register once it is free.
            ST_FINISH: begin
                if (out_free) begin
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_pay_next    = res_pay_reg;
                    out_fill_next   = used_reg;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            live_reg    <= '0;
            used_reg    <= '0;
            cap_reg     <= kstcd_pkg::CAP_RESET;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            live_reg    <= live_next;
            used_reg    <= used_next;
            cap_reg     <= cap_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            wr_ptr_reg  <= wr_ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        op_mode_reg    <= op_mode_next;
        op_rec_reg     <= op_rec_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_pay_reg    <= res_pay_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_pay_reg    <= out_pay_next;
        out_fill_reg   <= out_fill_next;
    end

    // Record memory.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, out_fill_reg, out_pay_reg, out_slot_reg, out_status_reg};

endmodule

`default_nettype wire

### design/kstcd_checker.sv
`default_nettype none

module kstcd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);

    // No result may be pending right after reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // One transaction at a time: the request side closes after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    // The fill mark never passes the number of slots.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[46:40] <= 7'(kstcd_pkg::NUM_SLOTS))
        else $error("fill count out of range");

    // A failed operation reports neither a slot nor a payload.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] != kstcd_pkg::STAT_OK
        |-> m_axis_tdata[39:2] == 38'd0)
        else $error("failed operation carries slot or payload");

endmodule

bind keyed_slot_table_cascade_delete_unit kstcd_checker u_kstcd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_SLOTS     = kstcd_pkg::NUM_SLOTS;
    localparam int IDX_W         = kstcd_pkg::IDX_W;
    localparam int FILL_W        = kstcd_pkg::FILL_W;
    localparam int KEY_W         = kstcd_pkg::KEY_W;
    localparam int PAYLOAD_BITS  = kstcd_pkg::PAYLOAD_BITS;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 16;
    localparam int POOL_SIZE     = 96;

    // One reply of the table: status, slot, found payload and fill mark.
    typedef struct {
        logic [1:0]              status;
        logic [IDX_W-1:0]        slot;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [FILL_W-1:0]       fill;
    } op_reply_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [6:0]  cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata  = '0;  // key[31:0], parent_key[63:32], payload[95:64]
    logic [1:0]  s_axis_tuser  = '0;  // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // status[1:0], slot_index[7:2], payload_out[39:8],
                                      // fill_count[46:40], zero[47]

    // Expected table contents, kept in step with every accepted transaction.
    bit                      rec_live    [NUM_SLOTS];
    logic [KEY_W-1:0]        rec_key     [NUM_SLOTS];
    logic [KEY_W-1:0]        rec_parent  [NUM_SLOTS];
    logic [PAYLOAD_BITS-1:0] rec_payload [NUM_SLOTS];
    int                      rec_fill     = 0;
    logic [6:0]              rec_capacity = kstcd_pkg::CAP_RESET;

    op_reply_t               replies_due[$];
    logic [KEY_W-1:0]        key_pool [POOL_SIZE];

    bit idling_on     = 1'b1;
    int ready_hold    = 0;
    int fail_count    = 0;
    int requests_sent = 0;
    int replies_seen  = 0;
    int status_seen [4];
    int cycle_count   = 0;

    keyed_slot_table_cascade_delete_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Mostly short pauses, now and then a long one, none while idling is off.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (!idling_on || pick < 45)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Capacities above the slot count behave as a full-size table.
    function automatic int slot_limit();
        return (int'(rec_capacity) > NUM_SLOTS) ? NUM_SLOTS : int'(rec_capacity);
    endfunction

    // First live slot below the fill mark that holds the key, or -1.
    function automatic int locate_key(logic [KEY_W-1:0] k);
        for (int s = 0; s < rec_fill; s++)
            if (rec_live[s] && rec_key[s] == k)
                return s;
        return -1;
    endfunction

    // Move live records down in order and lower the fill mark to the live count.
    function automatic void squeeze_table();
        int w;
        w = 0;
        for (int r = 0; r < rec_fill; r++) begin
            if (rec_live[r]) begin
                if (r != w) begin
                    rec_live[w]    = 1'b1;
                    rec_key[w]     = rec_key[r];
                    rec_parent[w]  = rec_parent[r];
                    rec_payload[w] = rec_payload[r];
                    rec_live[r]    = 1'b0;
                end
                w++;
            end
        end
        rec_fill = w;
    endfunction

    // Apply one request to the expected table and return the reply it must produce.
    function automatic op_reply_t table_op_reply(logic [1:0] mode, logic [KEY_W-1:0] k,
                                                 logic [KEY_W-1:0] par,
                                                 logic [PAYLOAD_BITS-1:0] pay);
        op_reply_t rep;
        int        hit;
        rep.status  = kstcd_pkg::STAT_OK;
        rep.slot    = '0;
        rep.payload = '0;
        hit = locate_key(k);
        case (mode)
            kstcd_pkg::MODE_INSERT: begin
                if (hit >= 0) begin
                    rep.status = kstcd_pkg::STAT_DUPLICATE;
                end else begin
                    if (rec_fill >= slot_limit())
                        squeeze_table();
                    if (rec_fill >= slot_limit()) begin
                        rep.status = kstcd_pkg::STAT_FULL;
                    end else begin
                        rec_live[rec_fill]    = 1'b1;
                        rec_key[rec_fill]     = k;
                        rec_parent[rec_fill]  = par;
                        rec_payload[rec_fill] = pay;
                        rep.slot = IDX_W'(rec_fill);
                        rec_fill++;
                    end
                end
            end
            kstcd_pkg::MODE_DELETE: begin
                if (hit < 0) begin
                    rep.status = kstcd_pkg::STAT_NOT_FOUND;
                end else begin
                    // The record and its direct children go; grandchildren stay.
                    rec_live[hit] = 1'b0;
                    for (int s = 0; s < rec_fill; s++)
                        if (rec_live[s] && rec_parent[s] == k)
                            rec_live[s] = 1'b0;
                    rep.slot = IDX_W'(hit);
                end
            end
            kstcd_pkg::MODE_FIND: begin
                if (hit < 0) begin
                    rep.status = kstcd_pkg::STAT_NOT_FOUND;
                end else begin
                    rep.slot    = IDX_W'(hit);
                    rep.payload = rec_payload[hit];
                end
            end
            kstcd_pkg::MODE_COMPACT: begin
                squeeze_table();
            end
            default: begin
            end
        endcase
        rep.fill = FILL_W'(rec_fill);
        return rep;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Present one request after a random gap and hold it until it is accepted.
    task automatic send_request(input logic [1:0] mode, input logic [KEY_W-1:0] k,
                                input logic [KEY_W-1:0] par,
                                input logic [PAYLOAD_BITS-1:0] pay);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {pay, par, k};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        replies_due.push_back(table_op_reply(mode, k, par, pay));
        requests_sent++;
    endtask

    // Stop sending and wait for every outstanding reply.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write the capacity register; only called while the table is idle.
    task automatic set_capacity(input logic [6:0] cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        rec_capacity = cap;
    endtask

    // Every operation on an empty and a small table, extreme keys and payloads,
    // a self-parented record, a grandchild that survives, and deletion of key zero.
    task automatic test_basic_ops();
        send_request(kstcd_pkg::MODE_FIND,    32'h1234_5678, 32'h0,         32'h0);
        send_request(kstcd_pkg::MODE_DELETE,  32'h0,         32'h0,         32'h0);
        send_request(kstcd_pkg::MODE_COMPACT, 32'h0,         32'h0,         32'h0);
        send_request(kstcd_pkg::MODE_INSERT,  32'h7FFF_FFFF, 32'h0,         32'hFFFF_FFFF);
        send_request(kstcd_pkg::MODE_INSERT,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_request(kstcd_pkg::MODE_INSERT,  32'h7FFF_FFFF, 32'h1,         32'h1);
        send_request(kstcd_pkg::MODE_INSERT,  32'h5,         32'h5,         32'h5A5A_5A5A);
        send_request(kstcd_pkg::MODE_INSERT,  32'h6,         32'h8000_0000, 32'hA5A5_A5A5);
        send_request(kstcd_pkg::MODE_INSERT,  32'h0,         32'hFFFF_FFFF, 32'h0000_FFFF);
        send_request(kstcd_pkg::MODE_INSERT,  32'h9,         32'h0,         32'hFFFF_0000);
        send_request(kstcd_pkg::MODE_FIND,    32'h8000_0000, 32'h0,         32'h0);
        send_request(kstcd_pkg::MODE_DELETE,  32'h7FFF_FFFF, 32'h0,         32'h0);
        send_request(kstcd_pkg::MODE_FIND,    32'h8000_0000, 32'h0,         32'h0);
        send_request(kstcd_pkg::MODE_FIND,    32'h6,         32'h0,         32'h0);
        send_request(kstcd_pkg::MODE_DELETE,  32'h5,         32'h0,         32'h0);
        send_request(kstcd_pkg::MODE_DELETE,  32'h0,         32'h0,         32'h0);
        send_request(kstcd_pkg::MODE_INSERT,  32'h5,         32'h0,         32'h1357_9BDF);
        send_request(kstcd_pkg::MODE_COMPACT, 32'h0,         32'h0,         32'h0);
        send_request(kstcd_pkg::MODE_FIND,    32'h6,         32'h0,         32'h0);
        wait_idle();
    endtask

    // Smallest capacity: compaction before insert, overflow, and a zero capacity.
    task automatic test_capacity_edges();
        set_capacity(7'd1);
        send_request(kstcd_pkg::MODE_INSERT,  32'h11,        32'h0,         32'hC0DE_0011);
        send_request(kstcd_pkg::MODE_DELETE,  32'h6,         32'h0,         32'h0);
        send_request(kstcd_pkg::MODE_DELETE,  32'h5,         32'h0,         32'h0);
        send_request(kstcd_pkg::MODE_INSERT,  32'h11,        32'h0,         32'hC0DE_0011);
        send_request(kstcd_pkg::MODE_INSERT,  32'h22,        32'h11,        32'hC0DE_0022);
        wait_idle();
        set_capacity(7'd0);
        send_request(kstcd_pkg::MODE_INSERT,  32'h33,        32'h0,         32'hC0DE_0033);
        send_request(kstcd_pkg::MODE_FIND,    32'h11,        32'h0,         32'h0);
        wait_idle();
    endtask

    // Keys drawn from a shared pool so that duplicates, hits and cascades occur.
    task automatic fill_key_pool();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'h8000_0000;
        key_pool[2] = 32'h7FFF_FFFF;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
    endtask

    // Random mix of operations at one capacity; n_keys sets how crowded the key space is.
    task automatic run_random_phase(input logic [6:0] cap, input int count, input int n_keys,
                                    input int insert_pct);
        logic [1:0]       mode;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] par;
        int               pick;
        set_capacity(cap);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < insert_pct)
                mode = kstcd_pkg::MODE_INSERT;
            else if (pick < insert_pct + (100 - insert_pct) * 2 / 5)
                mode = kstcd_pkg::MODE_DELETE;
            else if (pick < 94)
                mode = kstcd_pkg::MODE_FIND;
            else
                mode = kstcd_pkg::MODE_COMPACT;

            if ($urandom_range(0, 99) < 85)
                k = key_pool[$urandom_range(0, n_keys - 1)];
            else
                k = $urandom;

            pick = $urandom_range(0, 99);
            if (pick < 35)
                par = key_pool[$urandom_range(0, n_keys - 1)];
            else if (pick < 60)
                par = '0;
            else if (pick < 75)
                par = k;
            else
                par = $urandom;

            send_request(mode, k, par, $urandom);
        end
        wait_idle();
    endtask

    // Result side readiness: runs of ready broken by random stalls.
    always @(posedge aclk) begin : ready_gen
        int stall;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_axis_tready) begin
            stall = idle_length();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                ready_hold    <= stall - 1;
            end
        end else begin
            m_axis_tready <= 1'b1;
            ready_hold    <= $urandom_range(0, 10);
        end
    end

    // Compare each result transaction with the oldest reply still due.
    always @(posedge aclk) begin : reply_check
        op_reply_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            replies_seen++;
            status_seen[m_axis_tdata[1:0]]++;
            if (replies_due.size() == 0) begin
                $error("unexpected result transaction: tdata 0x%0h", m_axis_tdata);
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                check_field("status",      32'(want.status),  32'(m_axis_tdata[1:0]));
                check_field("slot_index",  32'(want.slot),    32'(m_axis_tdata[7:2]));
                check_field("payload_out", 32'(want.payload), 32'(m_axis_tdata[39:8]));
                check_field("fill_count",  32'(want.fill),    32'(m_axis_tdata[46:40]));
                check_field("pad bit",     32'h0,             32'(m_axis_tdata[47]));
            end
        end
    end

    // Give up if the run hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin : main_flow
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        fill_key_pool();

        test_basic_ops();
        test_capacity_edges();
        run_random_phase(7'd64,  220, 16, 50);
        run_random_phase(7'd8,   150, 12, 45);
        run_random_phase(7'd3,   100,  8, 40);
        run_random_phase(7'd1,    60,  6, 40);
        run_random_phase(7'd127, 250, 80, 70);

        // Last phase runs back to back with no pauses on either side.
        idling_on = 1'b0;
        run_random_phase(7'd64,  100, 80, 45);

        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Summary: %0d requests sent, %0d replies checked, %0d mismatches.",
                 requests_sent, replies_seen, fail_count);
        $display("Replies by status: ok %0d, duplicate %0d, full %0d, not found %0d; %s",
                 status_seen[kstcd_pkg::STAT_OK], status_seen[kstcd_pkg::STAT_DUPLICATE],
                 status_seen[kstcd_pkg::STAT_FULL], status_seen[kstcd_pkg::STAT_NOT_FOUND],
                 "capacities 64, 1, 0, 8, 3 and 127 used.");
        if (fail_count == 0 && replies_due.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### files.f
design/kstcd_pkg.sv
design/keyed_slot_table_cascade_delete_unit.sv
design/kstcd_checker.sv
tb/tb_top.sv
